FILE: hdl/eit_pkg.sv
// Shared types, constants and helper functions for the epipolar inlier test unit.
// Has no dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package eit_pkg;

  // Fixed field widths of the pair index and of the threshold.
  localparam int INDEX_WIDTH = 16;
  localparam int THR_WIDTH   = 16;

  // Threshold after reset: 1.0 pixel in unsigned Q8.8.
  localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd256;

  // Pixel coordinates carry four fraction bits, so the homogeneous 1 is 16.
  localparam int COORD_FRAC = 4;

  // Widest operand slice that the multiplier trees multiply in a single slice product.
  localparam int MUL_CHUNK = 32;

  // 3.84 = 96/25. With the scalings of D, L and T the test reads
  // 200 * D^2 * (A + B) < 3 * T^2 * A * B.
  localparam int               LHS_SCALE_W = 8;
  localparam logic [LHS_SCALE_W-1:0] LHS_SCALE = 8'd200;
  localparam int               RHS_SCALE_W = 2;
  localparam logic [RHS_SCALE_W-1:0] RHS_SCALE = 2'd3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ROW_ZERO  = 2'd0,
    CFG_ROW_ONE   = 2'd1,
    CFG_ROW_TWO   = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_index_t;

  // Cycles from operand registers to product register of eit_umul.
  function automatic int mul_latency(input int aw, input int bw);
    int na;
    int nb;
    na = (aw + MUL_CHUNK - 1) / MUL_CHUNK;
    nb = (bw + MUL_CHUNK - 1) / MUL_CHUNK;
    return 1 + $clog2(na * nb);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/eit_in_if.sv
// Correspondence channel: one point pair and its index per transaction.
// Depends on eit_pkg for the index width.
`timescale 1ns / 1ps
`default_nettype none

interface eit_in_if #(
  parameter int COORD_WIDTH = 16
);
  import eit_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] left_x;
  logic signed [COORD_WIDTH-1:0] left_y;
  logic signed [COORD_WIDTH-1:0] right_x;
  logic signed [COORD_WIDTH-1:0] right_y;
  logic [INDEX_WIDTH-1:0]        pair_index;

  modport source (
    output valid, left_x, left_y, right_x, right_y, pair_index,
    input  ready
  );

  modport sink (
    input  valid, left_x, left_y, right_x, right_y, pair_index,
    output ready
  );

endinterface

`default_nettype wire

FILE: hdl/eit_out_if.sv
// Result channel: inlier flag and echoed pair index per transaction.
// Depends on eit_pkg for the index width.
`timescale 1ns / 1ps
`default_nettype none

interface eit_out_if;
  import eit_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   is_inlier;
  logic [INDEX_WIDTH-1:0] result_index;

  modport source (
    output valid, is_inlier, result_index,
    input  ready
  );

  modport sink (
    input  valid, is_inlier, result_index,
    output ready
  );

endinterface

`default_nettype wire

FILE: hdl/eit_cfg_if.sv
// Configuration write channel: register index and write data per transaction.
// Depends on eit_pkg for the register index type.
`timescale 1ns / 1ps
`default_nettype none

interface eit_cfg_if #(
  parameter int DATA_WIDTH = 54
);
  import eit_pkg::*;

  logic                    valid;
  logic                    ready;
  eit_pkg::cfg_index_t     reg_index;
  logic [DATA_WIDTH-1:0]   write_data;

  modport source (
    output valid, reg_index, write_data,
    input  ready
  );

  modport sink (
    input  valid, reg_index, write_data,
    output ready
  );

endinterface

`default_nettype wire

FILE: hdl/eit_umul.sv
// Pipelined unsigned multiplier: slice products in one stage, then a registered adder tree.
// Depends on eit_pkg for the slice width.
`timescale 1ns / 1ps
`default_nettype none

module eit_umul #(
  parameter int A_WIDTH = 32,
  parameter int B_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [A_WIDTH-1:0]         a,
  input  logic [B_WIDTH-1:0]         b,
  output logic [A_WIDTH+B_WIDTH-1:0] p
);
  import eit_pkg::*;

  localparam int K      = MUL_CHUNK;
  localparam int KP     = 2 * K;
  localparam int NA     = (A_WIDTH + K - 1) / K;
  localparam int NB     = (B_WIDTH + K - 1) / K;
  localparam int NP     = NA * NB;
  localparam int LV     = $clog2(NP);
  localparam int NL     = 1 << LV;
  localparam int PW     = A_WIDTH + B_WIDTH;
  localparam int AX_W   = NA * K;
  localparam int BX_W   = NB * K;

  logic [AX_W-1:0] a_ext;
  logic [BX_W-1:0] b_ext;

  // Heap-ordered tree: node 0 is the root, leaves sit at NL-1 .. 2*NL-2.
  logic [PW-1:0] node_r [2*NL-1];

  assign a_ext = AX_W'(a);
  assign b_ext = BX_W'(b);

  genvar g;
  for (g = 0; g < NL; g++) begin : g_leaf
    if (g < NP) begin : g_pp
      localparam int IA = g / NB;
      localparam int IB = g % NB;
      localparam int SH = (IA + IB) * K;
      logic [KP-1:0] prod;
      assign prod = KP'(a_ext[IA*K +: K]) * KP'(b_ext[IB*K +: K]);
      always_ff @(posedge clk) begin
        if (en) begin
          node_r[NL-1+g] <= PW'(prod) << SH;
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (en) begin
          node_r[NL-1+g] <= '0;
        end
      end
    end
  end

  for (g = 0; g < NL - 1; g++) begin : g_node
    always_ff @(posedge clk) begin
      if (en) begin
        node_r[g] <= node_r[2*g+1] + node_r[2*g+2];
      end
    end
  end

  assign p = node_r[0];

endmodule

`default_nettype wire

FILE: hdl/epipolar_inlier_test_unit.sv
// Top level of the symmetric epipolar distance inlier test.
// Depends on eit_pkg, the eit_in_if, eit_out_if and eit_cfg_if interfaces, and eit_umul.
`timescale 1ns / 1ps
`default_nettype none

//  Channel    Direction  Payload                                        Moves on
//  in_chan    sink       left_x, left_y, right_x, right_y, pair_index  valid & ready
//  out_chan   source     is_inlier, result_index                       valid & ready
//  cfg_chan   sink       reg_index, write_data                         valid & ready
//
// One correspondence is taken per clock while the skid entry is empty. The pipeline
// depth is set by its longest path, through the multiplier trees for A*B and for
// T^2*A*B. Reset is synchronous and active low: it clears the pipeline valid
// bits and the output stage and loads F = 0 and a threshold of 1.0 pixel. A
// stalled output is caught by a one-entry skid register; the pipeline holds
// while the skid is full.

module epipolar_inlier_test_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 18
) (
  input  logic      clk,
  input  logic      rst_n,
  eit_in_if.sink    in_chan,
  eit_out_if.source out_chan,
  eit_cfg_if.sink   cfg_chan
);
  import eit_pkg::*;

  // Value widths. All products are exact; nothing is rounded or saturated.
  localparam int ROW_W  = 3 * COEF_WIDTH;
  localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;    // F entry times coordinate
  localparam int LINE_W = PROD_W + 2;                  // line coefficients l and r
  localparam int TERM_W = COORD_WIDTH + LINE_W;        // terms of the residual
  localparam int RES_W  = TERM_W + 2;                  // residual D
  localparam int SQS_W  = 2 * LINE_W;                  // A and B
  localparam int SUM_W  = SQS_W + 1;                   // A + B
  localparam int S200_W = SUM_W + LHS_SCALE_W;         // 200 * (A + B)
  localparam int DSQ_W  = 2 * RES_W;                   // D^2
  localparam int LHS_W  = DSQ_W + S200_W;
  localparam int TSQ_W  = 2 * THR_WIDTH;               // T^2
  localparam int TSQ3_W = TSQ_W + RHS_SCALE_W;         // 3 * T^2
  localparam int AB_W   = 2 * SQS_W;                   // A * B
  localparam int RHS_W  = AB_W + TSQ3_W;
  localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // Multiplier latencies.
  localparam int MSQ  = mul_latency(LINE_W, LINE_W);
  localparam int MD2  = mul_latency(RES_W, RES_W);
  localparam int MAB  = mul_latency(SQS_W, SQS_W);
  localparam int MLHS = mul_latency(DSQ_W, S200_W);
  localparam int MRHS = mul_latency(AB_W, TSQ3_W);

  // Stage numbers: stage 1 is loaded at the edge that accepts the transaction.
  // Stage 2 holds l and r, stage 3 the residual terms and line magnitudes,
  // stage 4 the residual and stage 5 its magnitude.
  localparam int S_SQ   = 3 + MSQ;                     // squared line coefficients
  localparam int S_AB0  = S_SQ + 1;                    // A and B
  localparam int S_S200 = S_AB0 + 2;                   // 200 * (A + B)
  localparam int S_AB   = S_AB0 + MAB;                 // A * B
  localparam int S_DSQ  = 5 + MD2;                     // D^2
  localparam int S_LIN  = (S_DSQ > S_S200) ? S_DSQ : S_S200;
  localparam int S_LHS  = S_LIN + MLHS;
  localparam int S_RHS  = S_AB + MRHS;
  localparam int S_CIN  = (S_LHS > S_RHS) ? S_LHS : S_RHS;
  localparam int S_FIN  = S_CIN + 1;                   // comparison result

  localparam int DSQ_DLY  = S_LIN - S_DSQ;
  localparam int S200_DLY = S_LIN - S_S200;
  localparam int LHS_DLY  = S_CIN - S_LHS;
  localparam int RHS_DLY  = S_CIN - S_RHS;

  // ---------------------------------------------------------------------------
  // Control: run flag, pipeline enable, input handshake.
  // ---------------------------------------------------------------------------
  logic run_r;
  logic en;
  logic in_acc;

  // The whole pipeline moves together; it only holds while the skid entry is full.
  logic skid_vld_r;
  assign en     = ~skid_vld_r;
  assign in_chan.ready = run_r & en;
  assign in_acc = in_chan.valid & in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are accepted once the run flag is set after reset.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]     row_r [3];
  logic [THR_WIDTH-1:0] thr_r;
  logic [TSQ_W-1:0]     tsq_r;
  logic [TSQ3_W-1:0]    tsq3_r;

  assign cfg_chan.ready = run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= '0;
      row_r[1] <= '0;
      row_r[2] <= '0;
      thr_r    <= THR_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.reg_index)
        CFG_ROW_ZERO:  row_r[0] <= cfg_chan.write_data[ROW_W-1:0];
        CFG_ROW_ONE:   row_r[1] <= cfg_chan.write_data[ROW_W-1:0];
        CFG_ROW_TWO:   row_r[2] <= cfg_chan.write_data[ROW_W-1:0];
        CFG_THRESHOLD: thr_r    <= cfg_chan.write_data[THR_WIDTH-1:0];
      endcase
    end
  end

  // 3 * T^2 follows the threshold through tsq_r and tsq3_r, long before any
  // transaction accepted after a write reaches the final product.
  always_ff @(posedge clk) begin
    tsq_r  <= TSQ_W'(thr_r) * TSQ_W'(thr_r);
    tsq3_r <= TSQ3_W'(tsq_r) * TSQ3_W'(RHS_SCALE);
  end

  // Matrix entries, F[i][j] at bits j*COEF_WIDTH of row i.
  logic signed [COEF_WIDTH-1:0] f_coef [3][3];

  genvar gi, gj;
  for (gi = 0; gi < 3; gi++) begin : g_frow
    for (gj = 0; gj < 3; gj++) begin : g_fcol
      assign f_coef[gi][gj] = row_r[gi][gj*COEF_WIDTH +: COEF_WIDTH];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: products of F with the coordinates. The homogeneous terms are
  // shifts and join in stage 2.
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0]      pl_r [3][2];
  logic signed [PROD_W-1:0]      pr_r [2][2];
  logic signed [COORD_WIDTH-1:0] xl0_s1_r;
  logic signed [COORD_WIDTH-1:0] xl1_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl_r[i][0] <= PROD_W'(f_coef[i][0]) * PROD_W'(in_chan.right_x);
        pl_r[i][1] <= PROD_W'(f_coef[i][1]) * PROD_W'(in_chan.right_y);
      end
      for (int i = 0; i < 2; i++) begin
        pr_r[i][0] <= PROD_W'(f_coef[0][i]) * PROD_W'(in_chan.left_x);
        pr_r[i][1] <= PROD_W'(f_coef[1][i]) * PROD_W'(in_chan.left_y);
      end
      xl0_s1_r <= in_chan.left_x;
      xl1_s1_r <= in_chan.left_y;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: epipolar lines l = F*xr and the first two entries of r = xl^T*F.
  // ---------------------------------------------------------------------------
  logic signed [LINE_W-1:0]      l_r [3];
  logic signed [LINE_W-1:0]      r_r [2];
  logic signed [COORD_WIDTH-1:0] xl0_s2_r;
  logic signed [COORD_WIDTH-1:0] xl1_s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l_r[i] <= LINE_W'(pl_r[i][0]) + LINE_W'(pl_r[i][1])
                  + (LINE_W'(f_coef[i][2]) <<< COORD_FRAC);
      end
      for (int i = 0; i < 2; i++) begin
        r_r[i] <= LINE_W'(pr_r[i][0]) + LINE_W'(pr_r[i][1])
                  + (LINE_W'(f_coef[2][i]) <<< COORD_FRAC);
      end
      xl0_s2_r <= xl0_s1_r;
      xl1_s2_r <= xl1_s1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: residual terms xl_i * l_i, and line magnitudes for the squarers.
  // Stage 4: residual D. Stage 5: |D|.
  // ---------------------------------------------------------------------------
  logic signed [TERM_W-1:0] t_r [3];
  logic [LINE_W-1:0]        mag_r [4];
  logic signed [RES_W-1:0]  d_r;
  logic [RES_W-1:0]         dmag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= TERM_W'(xl0_s2_r) * TERM_W'(l_r[0]);
      t_r[1] <= TERM_W'(xl1_s2_r) * TERM_W'(l_r[1]);
      t_r[2] <= TERM_W'(l_r[2]) <<< COORD_FRAC;
      for (int k = 0; k < 2; k++) begin
        mag_r[k]   <= l_r[k][LINE_W-1] ? $unsigned(-l_r[k]) : $unsigned(l_r[k]);
        mag_r[k+2] <= r_r[k][LINE_W-1] ? $unsigned(-r_r[k]) : $unsigned(r_r[k]);
      end
      d_r    <= RES_W'(t_r[0]) + RES_W'(t_r[1]) + RES_W'(t_r[2]);
      dmag_r <= d_r[RES_W-1] ? $unsigned(-d_r) : $unsigned(d_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Squares of l0, l1, r0, r1, then A, B, A + B and 200 * (A + B).
  // ---------------------------------------------------------------------------
  logic [SQS_W-1:0]  sq [4];
  logic [SQS_W-1:0]  sa_r;
  logic [SQS_W-1:0]  sb_r;
  logic [SUM_W-1:0]  sab_r;
  logic [S200_W-1:0] s200_r;

  for (gi = 0; gi < 4; gi++) begin : g_sq
    eit_umul #(
      .A_WIDTH (LINE_W),
      .B_WIDTH (LINE_W)
    ) u_sq (
      .clk (clk),
      .en  (en),
      .a   (mag_r[gi]),
      .b   (mag_r[gi]),
      .p   (sq[gi])
    );
  end

  // Each square stays below 2^(SQS_W-2), so the sums fit without a carry out.
  always_ff @(posedge clk) begin
    if (en) begin
      sa_r   <= sq[0] + sq[1];
      sb_r   <= sq[2] + sq[3];
      sab_r  <= SUM_W'(sa_r) + SUM_W'(sb_r);
      s200_r <= S200_W'(sab_r) * S200_W'(LHS_SCALE);
    end
  end

  // ---------------------------------------------------------------------------
  // D^2 and A * B.
  // ---------------------------------------------------------------------------
  logic [DSQ_W-1:0] dsq;
  logic [AB_W-1:0]  ab;

  eit_umul #(
    .A_WIDTH (RES_W),
    .B_WIDTH (RES_W)
  ) u_dsq (
    .clk (clk),
    .en  (en),
    .a   (dmag_r),
    .b   (dmag_r),
    .p   (dsq)
  );

  eit_umul #(
    .A_WIDTH (SQS_W),
    .B_WIDTH (SQS_W)
  ) u_ab (
    .clk (clk),
    .en  (en),
    .a   (sa_r),
    .b   (sb_r),
    .p   (ab)
  );

  // Align D^2 and 200 * (A + B) before they meet.
  logic [DSQ_W-1:0]  dsq_al;
  logic [S200_W-1:0] s200_al;

  if (DSQ_DLY == 0) begin : g_dsq_direct
    assign dsq_al = dsq;
  end else begin : g_dsq_delay
    logic [DSQ_W-1:0] dly_r [DSQ_DLY];
    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[0] <= dsq;
        for (int k = 1; k < DSQ_DLY; k++) begin
          dly_r[k] <= dly_r[k-1];
        end
      end
    end
    assign dsq_al = dly_r[DSQ_DLY-1];
  end

  if (S200_DLY == 0) begin : g_s200_direct
    assign s200_al = s200_r;
  end else begin : g_s200_delay
    logic [S200_W-1:0] dly_r [S200_DLY];
    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[0] <= s200_r;
        for (int k = 1; k < S200_DLY; k++) begin
          dly_r[k] <= dly_r[k-1];
        end
      end
    end
    assign s200_al = dly_r[S200_DLY-1];
  end

  // ---------------------------------------------------------------------------
  // The two sides of the test: 200*D^2*(A+B) and 3*T^2*A*B.
  // ---------------------------------------------------------------------------
  logic [LHS_W-1:0] lhs;
  logic [RHS_W-1:0] rhs;

  eit_umul #(
    .A_WIDTH (DSQ_W),
    .B_WIDTH (S200_W)
  ) u_lhs (
    .clk (clk),
    .en  (en),
    .a   (dsq_al),
    .b   (s200_al),
    .p   (lhs)
  );

  eit_umul #(
    .A_WIDTH (AB_W),
    .B_WIDTH (TSQ3_W)
  ) u_rhs (
    .clk (clk),
    .en  (en),
    .a   (ab),
    .b   (tsq3_r),
    .p   (rhs)
  );

  logic [LHS_W-1:0] lhs_al;
  logic [RHS_W-1:0] rhs_al;

  if (LHS_DLY == 0) begin : g_lhs_direct
    assign lhs_al = lhs;
  end else begin : g_lhs_delay
    logic [LHS_W-1:0] dly_r [LHS_DLY];
    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[0] <= lhs;
        for (int k = 1; k < LHS_DLY; k++) begin
          dly_r[k] <= dly_r[k-1];
        end
      end
    end
    assign lhs_al = dly_r[LHS_DLY-1];
  end

  if (RHS_DLY == 0) begin : g_rhs_direct
    assign rhs_al = rhs;
  end else begin : g_rhs_delay
    logic [RHS_W-1:0] dly_r [RHS_DLY];
    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[0] <= rhs;
        for (int k = 1; k < RHS_DLY; k++) begin
          dly_r[k] <= dly_r[k-1];
        end
      end
    end
    assign rhs_al = dly_r[RHS_DLY-1];
  end

  // Final stage. Both sides are non-negative; when A or B is zero the right
  // side is zero and the pair can never pass, which covers degenerate lines.
  logic inlier_r;

  always_ff @(posedge clk) begin
    if (en) begin
      inlier_r <= CMP_W'(lhs_al) < CMP_W'(rhs_al);
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits and pair indexes travel alongside the data.
  // ---------------------------------------------------------------------------
  logic [S_FIN-1:0]       vld_r;
  logic [INDEX_WIDTH-1:0] idx_r [S_FIN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[S_FIN-2:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r[0] <= in_chan.pair_index;
      for (int k = 1; k < S_FIN; k++) begin
        idx_r[k] <= idx_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid entry. A result leaves the pipeline whenever it
  // advances; if the output register is still held, the result parks in the
  // skid entry and the pipeline stops until the output is taken.
  // ---------------------------------------------------------------------------
  logic                   deliver;
  logic                   out_free;
  logic                   out_vld_r;
  logic                   out_vld_nxt;
  logic                   skid_vld_nxt;
  logic                   out_inl_r;
  logic [INDEX_WIDTH-1:0] out_idx_r;
  logic                   skid_inl_r;
  logic [INDEX_WIDTH-1:0] skid_idx_r;

  assign deliver  = en & vld_r[S_FIN-1];
  assign out_free = ~out_vld_r | out_chan.ready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_free) begin
      out_vld_nxt  = skid_vld_r | deliver;
      skid_vld_nxt = 1'b0;
    end else if (deliver) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_vld_r) begin
        out_inl_r <= skid_inl_r;
        out_idx_r <= skid_idx_r;
      end else begin
        out_inl_r <= inlier_r;
        out_idx_r <= idx_r[S_FIN-1];
      end
    end else if (deliver) begin
      skid_inl_r <= inlier_r;
      skid_idx_r <= idx_r[S_FIN-1];
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.is_inlier    = out_inl_r;
  assign out_chan.result_index = out_idx_r;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for epipolar_inlier_test_unit: directed table, then random phases.
// Depends on eit_pkg, the eit_in_if, eit_out_if and eit_cfg_if interfaces, and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import eit_pkg::*;

  // Widths of the block as instantiated here.
  localparam int COORD_W = 16;
  localparam int COEF_W  = 18;
  localparam int ROW_W   = 3 * COEF_W;

  // The exact test needs close to 200 bits; 320 leaves ample headroom.
  localparam int WIDE_W = 320;

  // Extremes of one signed Q1.16 matrix entry, and the value 1.0.
  localparam int COEF_MAX = 131071;
  localparam int COEF_MIN = -131072;
  localparam int UNIT     = 65536;

  // Shape of the random part of the run.
  localparam int PHASES          = 11;
  localparam int PAIRS_PER_PHASE = 50;
  localparam int PRESSURE_PHASE  = 5;

  // The tail wait after the last result leaves a margin for any stray result.
  localparam int DRAIN_CYCLES = 40;

  // About 570 transactions, with their idle gaps and the pipeline depth, stay far
  // below this limit.
  localparam int CYCLE_LIMIT = 400000;

  localparam int MAX_IDLE = 17;

  // Kinds of fundamental matrix used by the random phases. Stereo and skew matrices
  // let near-matching points through, so inliers and outliers both appear.
  typedef enum int {
    F_STEREO,
    F_SKEW,
    F_ARBITRARY
  } matrix_kind_t;

  typedef struct {
    logic                   is_inlier;
    logic [INDEX_WIDTH-1:0] result_index;
  } inlier_result_t;

  // One row of the directed table: either a register write or a correspondence.
  // Where the outcome is obvious, it is typed in and the predictor is not asked.
  typedef struct {
    bit                     is_write;
    cfg_index_t             reg_sel;
    logic [ROW_W-1:0]       data;
    logic [COORD_W-1:0]     lx;
    logic [COORD_W-1:0]     ly;
    logic [COORD_W-1:0]     rx;
    logic [COORD_W-1:0]     ry;
    logic [INDEX_WIDTH-1:0] idx;
    bit                     known;
    bit                     known_flag;
  } directed_row_t;

  logic clk;
  logic rst_n;

  eit_in_if #(.COORD_WIDTH(COORD_W)) in_chan ();
  eit_out_if                         out_chan ();
  eit_cfg_if #(.DATA_WIDTH(ROW_W))   cfg_chan ();

  epipolar_inlier_test_unit #(
    .COORD_WIDTH(COORD_W),
    .COEF_WIDTH (COEF_W)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // Testbench copy of the configuration registers, updated at each accepted write.
  logic [ROW_W-1:0]     row_model [3];
  logic [THR_WIDTH-1:0] thr_model;

  // Results still owed by the block, oldest first.
  inlier_result_t awaited_results [$];

  directed_row_t plan [$];

  int error_count = 0;
  int cycle_count = 0;
  int hold_cycles = 0;

  // When set, neither side idles: stretches of back-to-back transactions.
  bit no_idle = 1'b0;

  // Set while the write channel is still holding valid from its last transaction.
  bit cfg_busy = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A run that stops making progress ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time,
               awaited_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Pack three signed entries into one matrix row; entry 0 sits in the low bits.
  function automatic logic [ROW_W-1:0] pack_row(input int e0, input int e1, input int e2);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = e0;
    b = e1;
    c = e2;
    return {c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
  endfunction

  // Exact symmetric epipolar distance test under the current register copy.
  // With l = F*xr, r = xl^T*F, d = xl^T*F*xr, A = l0^2 + l1^2 and B = r0^2 + r1^2,
  // the pair passes when 200*d^2*(A+B) < 3*t^2*A*B. Either sum being zero fails it.
  function automatic logic predict_inlier(input logic [COORD_W-1:0] lx,
                                          input logic [COORD_W-1:0] ly,
                                          input logic [COORD_W-1:0] rx,
                                          input logic [COORD_W-1:0] ry);
    logic signed [WIDE_W-1:0] f [3][3];
    logic signed [WIDE_W-1:0] xl [3];
    logic signed [WIDE_W-1:0] xr [3];
    logic signed [WIDE_W-1:0] line_in_left [3];
    logic signed [WIDE_W-1:0] line_in_right [3];
    logic signed [WIDE_W-1:0] resid;
    logic signed [WIDE_W-1:0] sum_a;
    logic signed [WIDE_W-1:0] sum_b;
    logic signed [WIDE_W-1:0] thr;
    logic signed [WIDE_W-1:0] scale_l;
    logic signed [WIDE_W-1:0] scale_r;
    logic signed [WIDE_W-1:0] lhs;
    logic signed [WIDE_W-1:0] rhs;
    int i;
    int j;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        f[i][j] = WIDE_W'($signed(row_model[i][j*COEF_W +: COEF_W]));
      end
    end
    xl[0] = WIDE_W'($signed(lx));
    xl[1] = WIDE_W'($signed(ly));
    xl[2] = WIDE_W'(1 << COORD_FRAC);
    xr[0] = WIDE_W'($signed(rx));
    xr[1] = WIDE_W'($signed(ry));
    xr[2] = WIDE_W'(1 << COORD_FRAC);
    for (i = 0; i < 3; i++) begin
      line_in_left[i]  = f[i][0] * xr[0] + f[i][1] * xr[1] + f[i][2] * xr[2];
      line_in_right[i] = xl[0] * f[0][i] + xl[1] * f[1][i] + xl[2] * f[2][i];
    end
    resid = xl[0] * line_in_left[0] + xl[1] * line_in_left[1] + xl[2] * line_in_left[2];
    sum_a = line_in_left[0] * line_in_left[0] + line_in_left[1] * line_in_left[1];
    sum_b = line_in_right[0] * line_in_right[0] + line_in_right[1] * line_in_right[1];
    thr     = WIDE_W'(thr_model);
    scale_l = WIDE_W'(LHS_SCALE);
    scale_r = WIDE_W'(RHS_SCALE);
    lhs = scale_l * resid * resid * (sum_a + sum_b);
    rhs = scale_r * thr * thr * sum_a * sum_b;
    return (lhs < rhs);
  endfunction

  function automatic void add_write(input cfg_index_t sel, input logic [ROW_W-1:0] data);
    directed_row_t row;
    row.is_write   = 1'b1;
    row.reg_sel    = sel;
    row.data       = data;
    row.lx         = '0;
    row.ly         = '0;
    row.rx         = '0;
    row.ry         = '0;
    row.idx        = '0;
    row.known      = 1'b0;
    row.known_flag = 1'b0;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_pair(input int lx, input int ly, input int rx, input int ry,
                                   input int idx, input bit known, input bit known_flag);
    directed_row_t row;
    row.is_write   = 1'b0;
    row.reg_sel    = CFG_ROW_ZERO;
    row.data       = '0;
    row.lx         = lx[COORD_W-1:0];
    row.ly         = ly[COORD_W-1:0];
    row.rx         = rx[COORD_W-1:0];
    row.ry         = ry[COORD_W-1:0];
    row.idx        = idx[INDEX_WIDTH-1:0];
    row.known      = known;
    row.known_flag = known_flag;
    plan.insert(plan.size(), row);
  endfunction

  // Stop offering correspondences and wait until every owed result has been taken.
  task automatic quiesce();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // Registers change only with the pipeline empty. The task returns at the accepting
  // edge with valid still high, so a following write can keep it high.
  task automatic write_reg(input cfg_index_t sel, input logic [ROW_W-1:0] data);
    if (!cfg_busy) begin
      quiesce();
    end
    @(negedge clk);
    cfg_chan.reg_index  <= sel;
    cfg_chan.write_data <= data;
    cfg_chan.valid      <= 1'b1;
    do @(posedge clk); while (!cfg_chan.ready);
    if (sel == CFG_THRESHOLD) begin
      thr_model = data[THR_WIDTH-1:0];
    end else begin
      row_model[int'(sel)] = data;
    end
    cfg_busy = 1'b1;
  endtask

  // Offer one correspondence after a random gap and record what it must produce.
  // Returns at the accepting edge; valid stays high so the next one can follow at once.
  task automatic send_pair(input logic [COORD_W-1:0] lx, input logic [COORD_W-1:0] ly,
                           input logic [COORD_W-1:0] rx, input logic [COORD_W-1:0] ry,
                           input logic [INDEX_WIDTH-1:0] idx,
                           input bit known, input bit known_flag);
    int gap;
    inlier_result_t owed;
    if (cfg_busy) begin
      @(negedge clk);
      cfg_chan.valid <= 1'b0;
      cfg_busy = 1'b0;
    end
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.left_x     <= lx;
    in_chan.left_y     <= ly;
    in_chan.right_x    <= rx;
    in_chan.right_y    <= ry;
    in_chan.pair_index <= idx;
    in_chan.valid      <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    // The registers cannot change while results are owed, so predicting now is exact.
    owed.is_inlier    = known ? known_flag : predict_inlier(lx, ly, rx, ry);
    owed.result_index = idx;
    awaited_results.insert(awaited_results.size(), owed);
  endtask

  // Result side: ready drops for a freshly drawn number of cycles after each
  // accepted result, so stalls land on every stage of the pipeline.
  initial begin : result_pacing
    bit taken;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      taken = rst_n && out_chan.valid && out_chan.ready;
      @(negedge clk);
      if (taken) begin
        hold_cycles = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Every accepted result is matched against the oldest owed one, field by field.
  always @(posedge clk) begin : result_check
    inlier_result_t oldest;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result transaction: expected none, actual index %0d inlier %0d",
                 $time, out_chan.result_index, out_chan.is_inlier);
        error_count++;
      end else begin
        oldest = awaited_results.pop_front();
        if (out_chan.result_index !== oldest.result_index) begin
          $display("%0t: result_index mismatch: expected %0d, actual %0d", $time,
                   oldest.result_index, out_chan.result_index);
          error_count++;
        end
        if (out_chan.is_inlier !== oldest.is_inlier) begin
          $display("%0t: is_inlier mismatch for index %0d: expected %0d, actual %0d", $time,
                   oldest.result_index, oldest.is_inlier, out_chan.is_inlier);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    matrix_kind_t kind;
    logic [THR_WIDTH-1:0] thr_value;
    logic [63:0] filler;
    int e1;
    int e2;
    int e3;
    int c;
    int level;
    int spread;
    int lx;
    int ly;
    int rx;
    int ry;
    int phase;
    int n;

    // Every input is known from time zero, and reset is asserted at the start.
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.left_x      = '0;
    in_chan.left_y      = '0;
    in_chan.right_x     = '0;
    in_chan.right_y     = '0;
    in_chan.pair_index  = '0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.reg_index  = CFG_ROW_ZERO;
    cfg_chan.write_data = '0;

    // After reset the matrix is all zero and the threshold is one pixel.
    row_model[0] = '0;
    row_model[1] = '0;
    row_model[2] = '0;
    thr_model    = THR_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---------------------------------------------------------------------------------
    // Directed table.
    // ---------------------------------------------------------------------------------
    // With F all zero both lines vanish, so nothing can be an inlier.
    add_pair(0, 0, 0, 0, 0, 1, 0);
    add_pair(32767, 32767, 32767, 32767, 65535, 1, 0);
    add_pair(-32768, -32768, -32768, -32768, 1, 1, 0);

    // Rectified stereo: F = [0 0 0; 0 0 -1; 0 1 0]. The residual is proportional to the
    // vertical disparity, so equal rows pass and the rest depend on the threshold.
    add_write(CFG_ROW_ONE, pack_row(0, 0, -UNIT));
    add_write(CFG_ROW_TWO, pack_row(0, UNIT, 0));
    add_pair(1600, 800, -112, 800, 2, 1, 1);
    add_pair(32767, -32768, -32768, -32768, 3, 1, 1);
    add_pair(0, 0, 0, 32767, 4, 0, 0);
    add_pair(-50, 160, 77, 164, 5, 0, 0);
    add_pair(-50, 160, 77, 176, 6, 0, 0);
    add_pair(-50, 160, 77, 224, 7, 0, 0);

    // A zero threshold rejects even an exact match.
    add_write(CFG_THRESHOLD, ROW_W'(0));
    add_pair(10, 5, 20, 5, 8, 1, 0);

    // Largest threshold.
    add_write(CFG_THRESHOLD, ROW_W'(65535));
    add_pair(0, 0, 0, 32767, 9, 0, 0);
    add_pair(0, -32768, 0, 32767, 10, 0, 0);
    add_pair(-50, 160, 77, 224, 11, 0, 0);

    // Degenerate line in the right image: only F[1][2] set, so B is zero.
    add_write(CFG_ROW_TWO, ROW_W'(0));
    add_pair(40, -3, 41, -3, 12, 1, 0);

    // Degenerate line in the left image: only F[2][1] set, so A is zero.
    add_write(CFG_ROW_ONE, ROW_W'(0));
    add_write(CFG_ROW_TWO, pack_row(0, UNIT, 0));
    add_pair(40, -3, 41, -3, 13, 1, 0);

    // Extreme matrix entries with extreme coordinates.
    add_write(CFG_ROW_ZERO, pack_row(COEF_MAX, COEF_MAX, COEF_MAX));
    add_write(CFG_ROW_ONE, pack_row(COEF_MIN, COEF_MIN, COEF_MIN));
    add_write(CFG_ROW_TWO, pack_row(COEF_MAX, COEF_MIN, 0));
    add_pair(32767, 32767, 32767, 32767, 14, 0, 0);
    add_pair(-32768, -32768, -32768, -32768, 15, 0, 0);
    add_pair(32767, -32768, -32768, 32767, 65535, 0, 0);

    foreach (plan[k]) begin
      if (plan[k].is_write) begin
        write_reg(plan[k].reg_sel, plan[k].data);
      end else begin
        send_pair(plan[k].lx, plan[k].ly, plan[k].rx, plan[k].ry, plan[k].idx,
                  plan[k].known, plan[k].known_flag);
      end
    end

    // ---------------------------------------------------------------------------------
    // Random phases. Each one writes all four registers, then streams correspondences.
    // In stereo and skew phases most are near-matches for the chosen matrix; the rest are noise.
    // ---------------------------------------------------------------------------------
    for (phase = 0; phase < PHASES; phase++) begin
      kind = matrix_kind_t'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
        0: begin
          thr_value = '0;
        end
        1: begin
          thr_value = '1;
        end
        2: begin
          thr_value = THR_RESET;
        end
        3: begin
          thr_value = THR_WIDTH'($urandom_range(1, 1023));
        end
        default: begin
          thr_value = THR_WIDTH'($urandom_range(0, 65535));
        end
      endcase

      case (kind)
        F_STEREO: begin
          c = int'($urandom_range(1, COEF_MAX));
          if ($urandom_range(0, 1) == 1) c = -c;
          write_reg(CFG_ROW_ZERO, pack_row(0, 0, 0));
          write_reg(CFG_ROW_ONE, pack_row(0, 0, -c));
          write_reg(CFG_ROW_TWO, pack_row(0, c, 0));
        end
        F_SKEW: begin
          // F is the cross-product matrix of a random vector, so d vanishes when the
          // two points coincide.
          e1 = int'($urandom_range(0, 2 * COEF_MAX)) - COEF_MAX;
          e2 = int'($urandom_range(0, 2 * COEF_MAX)) - COEF_MAX;
          e3 = int'($urandom_range(0, 2 * COEF_MAX)) - COEF_MAX;
          write_reg(CFG_ROW_ZERO, pack_row(0, -e3, e2));
          write_reg(CFG_ROW_ONE, pack_row(e3, 0, -e1));
          write_reg(CFG_ROW_TWO, pack_row(-e2, e1, 0));
        end
        default: begin
          write_reg(CFG_ROW_ZERO, ROW_W'({$urandom, $urandom}));
          write_reg(CFG_ROW_ONE, ROW_W'({$urandom, $urandom}));
          write_reg(CFG_ROW_TWO, ROW_W'({$urandom, $urandom}));
        end
      endcase
      // Bits above the threshold field carry junk, which the block must ignore.
      filler = {$urandom, $urandom};
      write_reg(CFG_THRESHOLD, {filler[ROW_W-1:THR_WIDTH], thr_value});

      no_idle = (phase % 4 == 1);

      for (n = 0; n < PAIRS_PER_PHASE; n++) begin
        // Once in the run the sender holds off until the pipeline has emptied.
        if (phase == PRESSURE_PHASE && n == PAIRS_PER_PHASE / 2) begin
          quiesce();
        end

        level  = $urandom_range(0, 3);
        spread = (level == 0) ? 0 : (1 << (3 * level));
        lx = int'($urandom_range(0, 64000)) - 32000;
        ly = int'($urandom_range(0, 64000)) - 32000;
        rx = lx + int'($urandom_range(0, 2 * spread)) - spread;
        ry = ly + int'($urandom_range(0, 2 * spread)) - spread;
        if (kind == F_STEREO) begin
          rx = int'($urandom_range(0, 65535)) - 32768;
        end
        if (kind == F_ARBITRARY || $urandom_range(0, 4) == 0) begin
          lx = int'($urandom_range(0, 65535));
          ly = int'($urandom_range(0, 65535));
          rx = int'($urandom_range(0, 65535));
          ry = int'($urandom_range(0, 65535));
        end
        send_pair(lx[COORD_W-1:0], ly[COORD_W-1:0], rx[COORD_W-1:0], ry[COORD_W-1:0],
                  INDEX_WIDTH'($urandom_range(0, 65535)), 1'b0, 1'b0);
      end
    end

    // Let the last results out, then allow a margin for anything stray.
    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
